// ----- sv/tdca_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdca_pkg
// Shared types, widths and constants for the 2D conditional average block.
// ----------------------------------------------------------------------------
package tdca_pkg;

  localparam int BINS_I_MAX  = 64;
  localparam int BINS_J_MAX  = 64;
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = 12;
  localparam int SUM_W       = 48;
  localparam int CNT_W       = 32;
  localparam int VAL_W       = 32;
  localparam int BINS_W      = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IDX_I_W     = (BINS_I_MAX > 1) ? $clog2(BINS_I_MAX) : 1;
  localparam int IDX_J_W     = (BINS_J_MAX > 1) ? $clog2(BINS_J_MAX) : 1;
  localparam int FLAT_W      = IDX_J_W + BINS_W + 1;
  localparam int DIV_CNT_W   = $clog2(SUM_W);

  localparam logic [VAL_W-1:0] MEAN_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] MEAN_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [SUM_W-1:0] SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_ACCUM = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_I   = 3'd0,
    CFG_SCALE_I = 3'd1,
    CFG_BINS_I  = 3'd2,
    CFG_MIN_J   = 3'd3,
    CFG_SCALE_J = 3'd4,
    CFG_BINS_J  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]              command;
    logic signed [VAL_W-1:0] sample_value;
    logic signed [VAL_W-1:0] cond_i;
    logic signed [VAL_W-1:0] cond_j;
    logic [ADDR_W-1:0]       bin_address;
  } in_item_t;

  typedef struct packed {
    logic                    hit;
    logic [ADDR_W-1:0]       result_address;
    logic signed [SUM_W-1:0] bin_sum;
    logic [CNT_W-1:0]        bin_count;
    logic signed [VAL_W-1:0] bin_mean;
  } out_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    entry_t            wr_data;
  } store_req_t;

endpackage
`default_nettype wire

// ----- sv/tdca_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdca_if
// Valid/ready channels carrying command items in and result items out.
// ----------------------------------------------------------------------------
interface tdca_in_if;
  logic                valid;
  logic                ready;
  tdca_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tdca_out_if;
  logic                valid;
  logic                ready;
  tdca_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/tdca_binner.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdca_binner
// Two-stage bin index: offset from range start, then Q0.32 reciprocal scale.
// ----------------------------------------------------------------------------
module tdca_binner (
  input  wire logic                              clk_i,
  input  wire logic                              diff_en_i,
  input  wire logic                              mul_en_i,
  input  wire logic signed [tdca_pkg::VAL_W-1:0] cond_i,
  input  wire logic signed [tdca_pkg::VAL_W-1:0] min_i,
  input  wire logic [tdca_pkg::VAL_W-1:0]        scale_i,
  input  wire logic [tdca_pkg::BINS_W-1:0]       nbins_i,
  output logic                                   in_range_o,
  output logic [tdca_pkg::VAL_W-1:0]             bin_o
);
  import tdca_pkg::*;

  logic signed [VAL_W:0] diff;
  logic [VAL_W-1:0]      mag_q;
  logic                  miss_q;
  logic [2*VAL_W-1:0]    prod;
  logic [VAL_W-1:0]      bin_q;
  logic                  miss2_q;

  // A negative offset drops the sample unless the scale is zero (then bin 0).
  assign diff = {cond_i[VAL_W-1], cond_i} - {min_i[VAL_W-1], min_i};
  assign prod = mag_q * scale_i;

  always_ff @(posedge clk_i) begin
    if (diff_en_i) begin
      mag_q  <= diff[VAL_W-1:0];
      miss_q <= diff[VAL_W] && (scale_i != '0);
    end
    if (mul_en_i) begin
      bin_q   <= prod[2*VAL_W-1:VAL_W];
      miss2_q <= miss_q;
    end
  end

  assign in_range_o = !miss2_q && (bin_q < {{(VAL_W-BINS_W){1'b0}}, nbins_i});
  assign bin_o      = bin_q;

endmodule
`default_nettype wire

// ----- sv/tdca_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdca_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdca_divider (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [tdca_pkg::SUM_W-1:0]    dividend_i,
  input  wire logic [tdca_pkg::CNT_W-1:0]    divisor_i,
  output logic                               done_o,
  output logic [tdca_pkg::SUM_W-1:0]         quotient_o
);
  import tdca_pkg::*;

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0]     quo_q, quo_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]     dvs_q, dvs_d;
  logic [CNT_W:0]       shifted;
  logic [CNT_W:0]       trial;

  assign shifted = {rem_q, quo_q[SUM_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(SUM_W - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial[CNT_W]) begin
        rem_d = shifted[CNT_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b0};
      end else begin
        rem_d = trial[CNT_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b1};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
    if (busy_q && !start_i && cnt_q == '0) begin
      done_o = 1'b1;
    end
  end

  // Quotient is taken from the next-state value, so it is complete while done marks the last step.
  assign quotient_o = quo_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

endmodule
`default_nettype wire

// ----- sv/tdca_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdca_store
// Bin store: sum and count per bin, one port, registered read, zeroing sweep
// after reset.
// ----------------------------------------------------------------------------
module tdca_store (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire tdca_pkg::store_req_t req_i,
  output tdca_pkg::entry_t          rd_data_o,
  output logic                      clearing_o
);
  import tdca_pkg::*;

  entry_t            mem [STORE_DEPTH];
  logic              clr_busy_q;
  logic [ADDR_W-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_o <= mem[req_i.addr];
    end
  end

  assign clearing_o = clr_busy_q;

endmodule
`default_nettype wire

// ----- sv/two_dim_conditional_average.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_dim_conditional_average
// 2D binned conditional average: accumulate, read with mean, clear per bin.
// ----------------------------------------------------------------------------
// An accumulate whose sample falls outside the bins skips the store; a read
//   of an empty bin skips the 48-step divider. One item at a time: input ready
//   returns in the same cycle that the result reaches the output register.
// Bin store read-modify-write uses the S_RD and S_MOD states of an accumulate.
// Reset: config registers return to defaults; a sweep over all 4096 entries
//   zeroes the store, and input ready stays low until it ends.
module two_dim_conditional_average (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  tdca_in_if.sink                                  in_if,
  tdca_out_if.source                               out_if,
  input  wire logic                                cfg_we_i,
  input  wire logic [tdca_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [tdca_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import tdca_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DIFF = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_ADDR = 9'b000001000,
    S_RD   = 9'b000010000,
    S_MOD  = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_CLR  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic signed [VAL_W-1:0] min_i_q, min_j_q;
  logic [VAL_W-1:0]        scale_i_q, scale_j_q;
  logic [BINS_W-1:0]       bins_i_q, bins_j_q;
  logic [BINS_W-1:0]       nbins_i, nbins_j;

  // working item
  in_item_t          item_q, item_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  out_item_t         res_q, res_d;
  logic              neg_q, neg_d;

  // output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q, out_data_d;

  // datapath
  logic              in_range_i, in_range_j;
  logic [VAL_W-1:0]  bin_i, bin_j;
  logic [FLAT_W-1:0] flat;
  logic              accept;
  logic              clearing;
  store_req_t        store_req;
  entry_t            rd_data;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_new;
  logic [CNT_W-1:0]  cnt_new;
  logic [SUM_W-1:0]  sum_mag;
  logic [VAL_W-1:0]  sum_sat;
  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  quotient;
  logic [VAL_W-1:0]  mean_div;

  assign nbins_i = ({2'b0, bins_i_q} > (BINS_W + 2)'(BINS_I_MAX)) ?
                   BINS_W'(BINS_I_MAX) : bins_i_q;
  assign nbins_j = ({2'b0, bins_j_q} > (BINS_W + 2)'(BINS_J_MAX)) ?
                   BINS_W'(BINS_J_MAX) : bins_j_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_i_q   <= MEAN_MIN;
      min_j_q   <= MEAN_MIN;
      scale_i_q <= VAL_W'(65536);
      scale_j_q <= VAL_W'(65536);
      bins_i_q  <= BINS_W'(1);
      bins_j_q  <= BINS_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MIN_I:   min_i_q   <= cfg_data_i[VAL_W-1:0];
        CFG_SCALE_I: scale_i_q <= cfg_data_i[VAL_W-1:0];
        CFG_BINS_I:  bins_i_q  <= cfg_data_i[BINS_W-1:0];
        CFG_MIN_J:   min_j_q   <= cfg_data_i[VAL_W-1:0];
        CFG_SCALE_J: scale_j_q <= cfg_data_i[VAL_W-1:0];
        CFG_BINS_J:  bins_j_q  <= cfg_data_i[BINS_W-1:0];
        default: ;
      endcase
    end
  end

  tdca_binner u_bin_i (
    .clk_i      (clk_i),
    .diff_en_i  (state_q == S_DIFF),
    .mul_en_i   (state_q == S_MUL),
    .cond_i     (item_q.cond_i),
    .min_i      (min_i_q),
    .scale_i    (scale_i_q),
    .nbins_i    (nbins_i),
    .in_range_o (in_range_i),
    .bin_o      (bin_i)
  );

  tdca_binner u_bin_j (
    .clk_i      (clk_i),
    .diff_en_i  (state_q == S_DIFF),
    .mul_en_i   (state_q == S_MUL),
    .cond_i     (item_q.cond_j),
    .min_i      (min_j_q),
    .scale_i    (scale_j_q),
    .nbins_i    (nbins_j),
    .in_range_o (in_range_j),
    .bin_o      (bin_j)
  );

  assign flat = FLAT_W'(bin_i[IDX_I_W-1:0]) +
                FLAT_W'(bin_j[IDX_J_W-1:0]) * FLAT_W'(nbins_i);

  tdca_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (store_req),
    .rd_data_o  (rd_data),
    .clearing_o (clearing)
  );

  // read-modify-write arithmetic
  assign sum_ext = {rd_data.sum[SUM_W-1], rd_data.sum} +
                   {{(SUM_W+1-VAL_W){item_q.sample_value[VAL_W-1]}}, item_q.sample_value};
  assign sum_new = (sum_ext[SUM_W] != sum_ext[SUM_W-1]) ?
                   (sum_ext[SUM_W] ? SUM_MIN : SUM_MAX) : sum_ext[SUM_W-1:0];
  assign cnt_new = (&rd_data.count) ? rd_data.count : rd_data.count + 1'b1;
  assign sum_mag = rd_data.sum[SUM_W-1] ? (~rd_data.sum + 1'b1) : rd_data.sum;

  // raw sum clipped to the mean's range, used for an empty bin
  assign sum_sat = ((&rd_data.sum[SUM_W-1:VAL_W-1]) || !(|rd_data.sum[SUM_W-1:VAL_W-1])) ?
                   rd_data.sum[VAL_W-1:0] : (rd_data.sum[SUM_W-1] ? MEAN_MIN : MEAN_MAX);

  tdca_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_mag),
    .divisor_i  (rd_data.count),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    if (neg_q) begin
      mean_div = (quotient > {{(SUM_W-VAL_W){1'b0}}, MEAN_MIN}) ?
                 MEAN_MIN : (~quotient[VAL_W-1:0] + 1'b1);
    end else begin
      mean_div = (quotient > {{(SUM_W-VAL_W){1'b0}}, MEAN_MAX}) ?
                 MEAN_MAX : quotient[VAL_W-1:0];
    end
  end

  assign accept     = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == S_IDLE) && !clearing;

  always_comb begin
    state_d           = state_q;
    item_d            = item_q;
    addr_d            = addr_q;
    res_d             = res_q;
    neg_d             = neg_q;
    out_valid_d       = out_valid_q;
    out_data_d        = out_data_q;
    div_start         = 1'b0;
    store_req.rd_en   = 1'b0;
    store_req.wr_en   = 1'b0;
    store_req.addr    = addr_q;
    store_req.wr_data = '0;

    if (out_valid_q && out_if.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_d = in_if.data;
          addr_d = in_if.data.bin_address;
          res_d  = '0;
          case (in_if.data.command)
            CMD_ACCUM: state_d = S_DIFF;
            CMD_READ:  state_d = S_RD;
            CMD_CLEAR: state_d = S_CLR;
            default:   state_d = S_OUT;
          endcase
        end
      end
      S_DIFF: state_d = S_MUL;
      S_MUL:  state_d = S_ADDR;
      S_ADDR: begin
        addr_d = flat[ADDR_W-1:0];
        if (in_range_i && in_range_j && (flat < FLAT_W'(STORE_DEPTH))) begin
          state_d = S_RD;
        end else begin
          state_d = S_OUT;
        end
      end
      S_RD: begin
        store_req.rd_en = 1'b1;
        state_d         = S_MOD;
      end
      S_MOD: begin
        res_d.result_address = addr_q;
        if (item_q.command == CMD_ACCUM) begin
          store_req.wr_en         = 1'b1;
          store_req.wr_data.sum   = sum_new;
          store_req.wr_data.count = cnt_new;
          res_d.hit       = 1'b1;
          res_d.bin_sum   = sum_new;
          res_d.bin_count = cnt_new;
          state_d         = S_OUT;
        end else begin
          res_d.bin_sum   = rd_data.sum;
          res_d.bin_count = rd_data.count;
          if (rd_data.count == '0) begin
            res_d.bin_mean = sum_sat;
            state_d        = S_OUT;
          end else begin
            neg_d     = rd_data.sum[SUM_W-1];
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_d.bin_mean = mean_div;
          state_d        = S_OUT;
        end
      end
      S_CLR: begin
        store_req.wr_en      = 1'b1;
        res_d.result_address = addr_q;
        state_d              = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_if.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    addr_q     <= addr_d;
    res_q      <= res_d;
    neg_q      <= neg_d;
    out_data_q <= out_data_d;
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_data_q;

  // one item in flight: no transfer right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_if.ready)
    else $error("input taken while an item is in flight");

  // store writes never collide with the zeroing sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_req.wr_en |-> !clearing)
    else $error("store write during zeroing sweep");

  // an accumulate hit always leaves a nonzero count and no mean
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.data.hit) |->
      (out_if.data.bin_count != '0) && (out_if.data.bin_mean == '0))
    else $error("accumulate result has zero count or a mean");

  // the divider is started only from the read path of the modify step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (state_q == S_MOD) && (item_q.command == CMD_READ))
    else $error("divider started outside a read");

endmodule
`default_nettype wire
